@@ sv/tgd_pkg.sv @@
package tgd_pkg;

   localparam int NOW_W         = 32;
   localparam int CFG_W         = 16;
   localparam int CSR_ADDR_W    = 3;
   localparam int REQ_TDATA_W   = 40;
   localparam int RSP_TDATA_W   = 8;
   localparam int EVQ_DEPTH_DEF = 4;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_DEBOUNCE     = 3'd0,
      CSR_DCLICK_GUARD = 3'd1,
      CSR_MAX_CLICK    = 3'd2,
      CSR_HOLD         = 3'd3,
      CSR_HOLD_NOTIFY  = 3'd4,
      CSR_SINGLE_DELAY = 3'd5,
      CSR_LOCKOUT      = 3'd6
   } csr_idx_type;

   typedef enum logic [5:0] {
      GS_IDLE     = 6'b000001,
      GS_PRESSED  = 6'b000010,
      GS_CLICK    = 6'b000100,
      GS_RELEASED = 6'b001000,
      GS_HOLD     = 6'b010000,
      GS_BOTH     = 6'b100000
   } gst_type;

   typedef enum logic [1:0] {
      EV_HOLD_NOTE = 2'd0,
      EV_HOLD_REL  = 2'd1,
      EV_CLICK     = 2'd2,
      EV_RELEASE   = 2'd3
   } evk_type;

   typedef enum logic [1:0] {
      BTN_LEFT  = 2'd0,
      BTN_RIGHT = 2'd1,
      BTN_BOTH  = 2'd2
   } btn_code_type;

   typedef struct packed {
      logic [CFG_W-1:0] debounce;
      logic [CFG_W-1:0] dclick_guard;
      logic [CFG_W-1:0] max_click;
      logic [CFG_W-1:0] hold;
      logic [CFG_W-1:0] hold_notify;
      logic [CFG_W-1:0] single_delay;
      logic [CFG_W-1:0] lockout;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      debounce:     16'd50,
      dclick_guard: 16'd100,
      max_click:    16'd500,
      hold:         16'd1000,
      hold_notify:  16'd3000,
      single_delay: 16'd1500,
      lockout:      16'd500
   };

   typedef struct packed {
      logic [NOW_W-1:0] now_ms;
      logic [1:0]       level;
      logic [1:0]       edge_flag;
   } tick_type;

   typedef struct packed {
      gst_type          gst;
      gst_type          prev;
      logic             is_pressed;
      logic             press_pending;
      logic             release_pending;
      logic             state_changed;
      logic             long_hold_mark;
      logic             edge_pending;
      logic [NOW_W-1:0] press_stamp;
      logic [NOW_W-1:0] release_stamp;
   } btn_type;

   localparam btn_type BTN_RESET = '{
      gst:             GS_IDLE,
      prev:            GS_IDLE,
      is_pressed:      1'b0,
      press_pending:   1'b0,
      release_pending: 1'b0,
      state_changed:   1'b0,
      long_hold_mark:  1'b0,
      edge_pending:    1'b0,
      press_stamp:     '0,
      release_stamp:   '0
   };

   typedef struct packed {
      evk_type      kind;
      btn_code_type button;
   } ev_type;

   typedef struct packed {
      logic [1:0] cnt;
      ev_type     ev0;
      ev_type     ev1;
   } evpair_type;

   typedef struct packed {
      evk_type      kind;
      btn_code_type button;
      logic         last;
   } qent_type;

   // elapsed time since a stamp is within the window; a zero stamp means never, so never inside it
   function automatic logic in_window(logic [NOW_W-1:0] now, logic [NOW_W-1:0] stamp,
                                      logic [CFG_W-1:0] win);
      logic [NOW_W-1:0] dt;
      dt = now - stamp;
      return (dt <= {{(NOW_W-CFG_W){1'b0}}, win}) && (stamp != '0);
   endfunction

   function automatic logic elapsed_ge(logic [NOW_W-1:0] now, logic [NOW_W-1:0] stamp,
                                       logic [CFG_W-1:0] lim);
      logic [NOW_W-1:0] dt;
      dt = now - stamp;
      return dt >= {{(NOW_W-CFG_W){1'b0}}, lim};
   endfunction

   function automatic btn_type sample_btn(btn_type s, logic lvl, logic [NOW_W-1:0] now,
                                          cfg_type c);
      btn_type r;
      r = s;
      if (s.edge_pending) begin
         if (lvl) begin
            if (!in_window(now, s.press_stamp, c.debounce) &&
                !in_window(now, s.release_stamp, c.dclick_guard)) begin
               r.is_pressed    = 1'b1;
               r.press_pending = 1'b1;
               r.press_stamp   = now;
               r.edge_pending  = 1'b0;
            end
         end else begin
            if (!in_window(now, s.release_stamp, c.debounce)) begin
               r.release_pending = 1'b1;
               r.is_pressed      = 1'b0;
               r.release_stamp   = now;
               r.edge_pending    = 1'b0;
            end
         end
      end
      return r;
   endfunction

   function automatic btn_type update_btn(btn_type s, logic [NOW_W-1:0] now, cfg_type c);
      btn_type r;
      gst_type g;
      r      = s;
      r.prev = s.gst;
      g      = s.gst;
      if (s.press_pending) begin
         g               = GS_PRESSED;
         r.press_pending = 1'b0;
      end
      if (g == GS_CLICK && !s.release_pending) begin
         g = GS_IDLE;
      end
      if (s.release_pending) begin
         r.release_stamp   = now;
         r.release_pending = 1'b0;
         g = elapsed_ge(now, s.press_stamp, c.max_click) &&
             !in_window(now, s.press_stamp, c.max_click) &&
             ((now - s.press_stamp) != {{(NOW_W-CFG_W){1'b0}}, c.max_click})
             ? GS_RELEASED : GS_CLICK;
      end
      if (s.is_pressed && elapsed_ge(now, s.press_stamp, c.hold)) begin
         if (elapsed_ge(now, s.press_stamp, c.hold_notify)) begin
            r.long_hold_mark = 1'b1;
         end
         g = GS_HOLD;
      end
      r.gst           = g;
      r.state_changed = (s.gst != g);
      return r;
   endfunction

   function automatic evpair_type push_ev(evpair_type p, evk_type k, btn_code_type b);
      evpair_type r;
      r = p;
      if (p.cnt == 2'd0) begin
         r.ev0 = '{kind: k, button: b};
         r.cnt = 2'd1;
      end else if (p.cnt == 2'd1) begin
         r.ev1 = '{kind: k, button: b};
         r.cnt = 2'd2;
      end
      return r;
   endfunction

endpackage

@@ sv/tgd_core.sv @@
module tgd_core
   import tgd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  tick_type   tick,
   input  cfg_type    cfg,
   output evpair_type evs
);

   btn_type          left_ff, right_ff;
   btn_type          left_in, right_in;
   logic [NOW_W-1:0] both_rel_ff, both_rel_in;

   btn_type l0, l1, l2, l3;
   btn_type r0, r1, r2, r3;
   logic    hold_both, lock_over, hold_l, hold_r;
   logic    both_prev, any_changed;

   // left updates, both sample, right updates, both sample again
   always_comb begin
      l0 = left_ff;
      r0 = right_ff;
      l0.edge_pending = left_ff.edge_pending | tick.edge_flag[0];
      r0.edge_pending = right_ff.edge_pending | tick.edge_flag[1];
      l1 = update_btn(l0, tick.now_ms, cfg);
      l2 = sample_btn(l1, tick.level[0], tick.now_ms, cfg);
      r1 = sample_btn(r0, tick.level[1], tick.now_ms, cfg);
      r2 = update_btn(r1, tick.now_ms, cfg);
      l3 = sample_btn(l2, tick.level[0], tick.now_ms, cfg);
      r3 = sample_btn(r2, tick.level[1], tick.now_ms, cfg);
   end

   always_comb begin
      hold_both   = (l3.long_hold_mark || r3.long_hold_mark) &&
                    (l3.state_changed || r3.state_changed);
      lock_over   = elapsed_ge(tick.now_ms, both_rel_ff, cfg.lockout);
      both_prev   = (l3.prev == GS_BOTH) && (r3.prev == GS_BOTH);
      hold_l      = (l3.gst == GS_HOLD) &&
                    elapsed_ge(tick.now_ms, l3.press_stamp, cfg.single_delay) && !both_prev;
      hold_r      = (r3.gst == GS_HOLD) &&
                    elapsed_ge(tick.now_ms, r3.press_stamp, cfg.single_delay) && !both_prev;
      any_changed = l3.state_changed || r3.state_changed;
   end

   always_comb begin
      left_in     = l3;
      right_in    = r3;
      both_rel_in = both_rel_ff;
      evs         = '{cnt: 2'd0, ev0: '{kind: EV_HOLD_NOTE, button: BTN_LEFT},
                      ev1: '{kind: EV_HOLD_NOTE, button: BTN_LEFT}};
      priority if (l3.gst == GS_HOLD && r3.gst == GS_HOLD) begin
         left_in.gst  = GS_BOTH;
         right_in.gst = GS_BOTH;
         if (hold_both) begin
            evs = push_ev(evs, EV_HOLD_NOTE, BTN_BOTH);
         end
      end else if (l3.gst == GS_BOTH || r3.gst == GS_BOTH) begin
         if (hold_both) begin
            evs = push_ev(evs, EV_HOLD_NOTE, BTN_BOTH);
         end
      end else if (hold_l) begin
         if (lock_over && l3.state_changed) begin
            evs = push_ev(evs, EV_HOLD_NOTE, BTN_LEFT);
         end
      end else if (hold_r) begin
         if (lock_over && r3.state_changed) begin
            evs = push_ev(evs, EV_HOLD_NOTE, BTN_RIGHT);
         end
      end else if (l3.gst == GS_CLICK || r3.gst == GS_CLICK) begin
         if (l3.gst == GS_CLICK) begin
            evs = push_ev(evs, EV_CLICK, BTN_LEFT);
            left_in.long_hold_mark = 1'b0;
         end
         if (r3.gst == GS_CLICK) begin
            evs = push_ev(evs, EV_CLICK, BTN_RIGHT);
            right_in.long_hold_mark = 1'b0;
         end
      end else if (l3.gst == GS_RELEASED || r3.gst == GS_RELEASED) begin
         if (l3.prev == GS_BOTH || r3.prev == GS_BOTH) begin
            both_rel_in = tick.now_ms;
            if (any_changed) begin
               evs = push_ev(evs, EV_HOLD_REL, BTN_BOTH);
            end
         end else if (lock_over) begin
            if (l3.gst == GS_RELEASED) begin
               if (l3.state_changed) begin
                  evs = push_ev(evs, (l3.prev == GS_HOLD) ? EV_HOLD_REL : EV_RELEASE,
                                BTN_LEFT);
               end
               left_in.long_hold_mark = 1'b0;
            end
            if (r3.gst == GS_RELEASED) begin
               if (r3.state_changed) begin
                  evs = push_ev(evs, (r3.prev == GS_HOLD) ? EV_HOLD_REL : EV_RELEASE,
                                BTN_RIGHT);
               end
               right_in.long_hold_mark = 1'b0;
            end
         end
      end else begin
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff     <= BTN_RESET;
         right_ff    <= BTN_RESET;
         both_rel_ff <= '0;
      end else if (step) begin
         left_ff     <= left_in;
         right_ff    <= right_in;
         both_rel_ff <= both_rel_in;
      end
   end

   // an edge is either still pending or has stamped the tick's time
   a_left_edge_kept: assert property (@(posedge clock) disable iff (reset)
      step && tick.edge_flag[0] |=> left_ff.edge_pending ||
         left_ff.press_stamp == $past(tick.now_ms) ||
         left_ff.release_stamp == $past(tick.now_ms))
      else $error("left edge lost");

   a_right_edge_kept: assert property (@(posedge clock) disable iff (reset)
      step && tick.edge_flag[1] |=> right_ff.edge_pending ||
         right_ff.press_stamp == $past(tick.now_ms) ||
         right_ff.release_stamp == $past(tick.now_ms))
      else $error("right edge lost");

   // two events only come from the per-button loops, left first
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      step && evs.cnt == 2'd2 |-> evs.ev0.button == BTN_LEFT && evs.ev1.button == BTN_RIGHT)
      else $error("event pair out of order");

endmodule

@@ sv/tgd_evq.sv @@
module tgd_evq
   import tgd_pkg::*;
#(
   parameter int DEPTH = EVQ_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  evpair_type pair,
   output logic       room,
   output logic       m_valid,
   input  logic       m_ready,
   output qent_type   m_data
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   qent_type        mem_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PW-1:0]   wr_ptr_nx;
   logic [CW-1:0]   count_ff, count_in;
   logic [1:0]      n_push;
   logic            pop;
   qent_type        ent0, ent1;

   function automatic logic [PW-1:0] inc_ptr(logic [PW-1:0] p);
      return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   always_comb begin
      n_push    = push ? pair.cnt : 2'd0;
      pop       = m_valid && m_ready;
      wr_ptr_nx = inc_ptr(wr_ptr_ff);
      ent0      = '{kind: pair.ev0.kind, button: pair.ev0.button, last: (pair.cnt == 2'd1)};
      ent1      = '{kind: pair.ev1.kind, button: pair.ev1.button, last: 1'b1};
      unique case (n_push)
         2'd1:    wr_ptr_in = wr_ptr_nx;
         2'd2:    wr_ptr_in = inc_ptr(wr_ptr_nx);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in = pop ? inc_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CW'(n_push) - CW'(pop);
   end

   assign room    = (count_ff <= CW'(DEPTH - 2));
   assign m_valid = (count_ff != '0);
   assign m_data  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         mem_ff[wr_ptr_ff] <= ent0;
      end
      if (n_push == 2'd2) begin
         mem_ff[wr_ptr_nx] <= ent1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("event queue overflow");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push |-> room)
      else $error("push without two free slots");

   a_pair_fill: assert property (@(posedge clock) disable iff (reset)
      n_push == 2'd2 && !pop |=> count_ff == $past(count_ff) + CW'(2))
      else $error("pair push miscounted");

endmodule

@@ sv/two_button_gesture_detector.sv @@
// Two-button click and hold detector. Each req word is one update tick (time in ms,
// both pin levels, both edge flags) and yields zero, one or two event words on rsp;
// rsp_tlast marks the final event of a tick. A tick is taken every cycle while the
// event queue (EVQ_DEPTH entries) has two free slots; events leave at one word per
// cycle while rsp_tready is high, so sustained rate is one tick per cycle for ticks
// with at most one event and one event per cycle otherwise. A tick passes the input
// register, then the gesture logic writes its events into the queue. Registers are
// written on csr_we, index on csr_addr, and must only change while the block is idle.
module two_button_gesture_detector
   import tgd_pkg::*;
#(
   parameter int EVQ_DEPTH = EVQ_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [31:0] now_ms, [32] left_level, [33] right_level, [34] left_edge, [35] right_edge
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [1:0] event_button
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // [1:0] event_kind
   output logic [1:0]             rsp_tuser,
   output logic                   rsp_tlast,
   input  logic                   csr_we,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [CFG_W-1:0]       csr_wdata
);

   cfg_type    cfg_ff;
   logic       in_valid_ff;
   tick_type   in_tick_ff;
   logic       room, fire;
   evpair_type evs;
   qent_type   q_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_addr))
            CSR_DEBOUNCE:     cfg_ff.debounce     <= csr_wdata;
            CSR_DCLICK_GUARD: cfg_ff.dclick_guard <= csr_wdata;
            CSR_MAX_CLICK:    cfg_ff.max_click    <= csr_wdata;
            CSR_HOLD:         cfg_ff.hold         <= csr_wdata;
            CSR_HOLD_NOTIFY:  cfg_ff.hold_notify  <= csr_wdata;
            CSR_SINGLE_DELAY: cfg_ff.single_delay <= csr_wdata;
            CSR_LOCKOUT:      cfg_ff.lockout      <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign fire       = in_valid_ff && room;
   assign req_tready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_tick_ff <= '{now_ms:    req_tdata[NOW_W-1:0],
                         level:     {req_tdata[33], req_tdata[32]},
                         edge_flag: {req_tdata[35], req_tdata[34]}};
      end
   end

   tgd_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (fire),
      .tick  (in_tick_ff),
      .cfg   (cfg_ff),
      .evs   (evs)
   );

   tgd_evq #(
      .DEPTH (EVQ_DEPTH)
   ) u_evq (
      .clock   (clock),
      .reset   (reset),
      .push    (fire),
      .pair    (evs),
      .room    (room),
      .m_valid (rsp_tvalid),
      .m_ready (rsp_tready),
      .m_data  (q_data)
   );

   assign rsp_tdata = {{(RSP_TDATA_W-2){1'b0}}, q_data.button};
   assign rsp_tuser = q_data.kind;
   assign rsp_tlast = q_data.last;

endmodule

@@ tb/testbench.sv @@
module testbench;
   import tgd_pkg::*;

   localparam int                    STALL_LIMIT    = 2000;
   localparam int                    HOLDOFF_CYCLES = 200;
   localparam logic [CSR_ADDR_W-1:0] CSR_UNUSED     = 3'd7;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [1:0]             rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_addr   = '0;
   logic [CFG_W-1:0]       csr_wdata  = '0;

   always #1 clock = ~clock;

   two_button_gesture_detector u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // gesture predictor state, per button
   typedef struct {
      gst_type   st;
      gst_type   prev_st;
      bit        held;
      bit        press_due;
      bit        release_due;
      bit        moved;
      bit        long_mark;
      bit        edge_due;
      bit [31:0] t_press;
      bit [31:0] t_release;
      bit [31:0] t_both_release;
   } button_model_type;

   button_model_type btn [2];
   bit [CFG_W-1:0]   timing [7];
   bit [31:0]        tick_ms;
   bit [1:0]         tick_level;
   qent_type         tick_events [$];
   qent_type         events_due [$];

   int unsigned send_idle_pct  = 0;
   int unsigned rsp_stall_pct  = 0;
   int          holdoffs_asked = 0;
   int          ticks_taken    = 0;
   int          words_checked  = 0;
   int          fail_count     = 0;
   bit [31:0]   wall_ms        = 32'd0;
   bit [1:0]    pins           = 2'b00;
   int          ms_scale       = 1;

   function automatic bit within_ms(bit [31:0] stamp, bit [CFG_W-1:0] win);
      return ((tick_ms - stamp) <= {16'h0, win}) && (stamp != 32'd0);
   endfunction

   function automatic bit aged_ms(bit [31:0] stamp, bit [CFG_W-1:0] lim);
      return (tick_ms - stamp) >= {16'h0, lim};
   endfunction

   function automatic void reset_model();
      for (int b = 0; b < 2; b++) begin
         btn[b] = '{st: GS_IDLE, prev_st: GS_IDLE, default: '0};
      end
      timing[CSR_DEBOUNCE]     = CFG_RESET.debounce;
      timing[CSR_DCLICK_GUARD] = CFG_RESET.dclick_guard;
      timing[CSR_MAX_CLICK]    = CFG_RESET.max_click;
      timing[CSR_HOLD]         = CFG_RESET.hold;
      timing[CSR_HOLD_NOTIFY]  = CFG_RESET.hold_notify;
      timing[CSR_SINGLE_DELAY] = CFG_RESET.single_delay;
      timing[CSR_LOCKOUT]      = CFG_RESET.lockout;
   endfunction

   // rejected edges stay pending and are retried on the next sample
   function automatic void qualify_edge(int b);
      if (!btn[b].edge_due) return;
      if (tick_level[b]) begin
         if (within_ms(btn[b].t_press, timing[CSR_DEBOUNCE])) return;
         if (within_ms(btn[b].t_release, timing[CSR_DCLICK_GUARD])) return;
         btn[b].held      = 1'b1;
         btn[b].press_due = 1'b1;
         btn[b].t_press   = tick_ms;
      end else begin
         if (within_ms(btn[b].t_release, timing[CSR_DEBOUNCE])) return;
         btn[b].release_due = 1'b1;
         btn[b].held        = 1'b0;
         btn[b].t_release   = tick_ms;
      end
      btn[b].edge_due = 1'b0;
   endfunction

   function automatic void advance_button(int b);
      btn[b].prev_st = btn[b].st;
      if (btn[b].press_due) begin
         btn[b].st        = GS_PRESSED;
         btn[b].press_due = 1'b0;
      end
      if (btn[b].st == GS_CLICK && !btn[b].release_due) btn[b].st = GS_IDLE;
      if (btn[b].release_due) begin
         btn[b].t_release = tick_ms;
         if ((tick_ms - btn[b].t_press) <= {16'h0, timing[CSR_MAX_CLICK]}) begin
            btn[b].st = GS_CLICK;
         end else begin
            btn[b].st = GS_RELEASED;
         end
         btn[b].release_due = 1'b0;
      end
      if (btn[b].held && aged_ms(btn[b].t_press, timing[CSR_HOLD])) begin
         if (aged_ms(btn[b].t_press, timing[CSR_HOLD_NOTIFY])) btn[b].long_mark = 1'b1;
         btn[b].st = GS_HOLD;
      end
      btn[b].moved = btn[b].prev_st != btn[b].st;
      qualify_edge(0);
      qualify_edge(1);
   endfunction

   function automatic void add_event(evk_type k, btn_code_type who);
      if (tick_events.size() < 2) tick_events.push_back('{kind: k, button: who, last: 1'b0});
   endfunction

   function automatic bit lockout_done();
      return aged_ms(btn[0].t_both_release, timing[CSR_LOCKOUT]) &&
             aged_ms(btn[1].t_both_release, timing[CSR_LOCKOUT]);
   endfunction

   function automatic void note_both_hold();
      if ((btn[0].long_mark || btn[1].long_mark) && (btn[0].moved || btn[1].moved))
         add_event(EV_HOLD_NOTE, BTN_BOTH);
   endfunction

   // priority: both-hold, single hold, clicks, releases
   function automatic void settle_events();
      if (btn[0].st == GS_HOLD && btn[1].st == GS_HOLD) begin
         btn[0].st = GS_BOTH;
         btn[1].st = GS_BOTH;
         note_both_hold();
         return;
      end
      if (btn[0].st == GS_BOTH || btn[1].st == GS_BOTH) begin
         note_both_hold();
         return;
      end
      for (int b = 0; b < 2; b++) begin
         if (btn[b].st == GS_HOLD && aged_ms(btn[b].t_press, timing[CSR_SINGLE_DELAY]) &&
             (btn[0].prev_st != GS_BOTH || btn[1].prev_st != GS_BOTH)) begin
            if (lockout_done() && btn[b].moved) add_event(EV_HOLD_NOTE, btn_code_type'(b));
            return;
         end
      end
      if (btn[0].st == GS_CLICK || btn[1].st == GS_CLICK) begin
         for (int b = 0; b < 2; b++) begin
            if (btn[b].st == GS_CLICK) begin
               add_event(EV_CLICK, btn_code_type'(b));
               btn[b].long_mark = 1'b0;
            end
         end
         return;
      end
      if (btn[0].st == GS_RELEASED || btn[1].st == GS_RELEASED) begin
         if (btn[0].prev_st == GS_BOTH || btn[1].prev_st == GS_BOTH) begin
            btn[0].t_both_release = tick_ms;
            btn[1].t_both_release = tick_ms;
            if (btn[0].moved || btn[1].moved) add_event(EV_HOLD_REL, BTN_BOTH);
            return;
         end
         if (lockout_done()) begin
            for (int b = 0; b < 2; b++) begin
               if (btn[b].st == GS_RELEASED) begin
                  if (btn[b].moved) begin
                     if (btn[b].prev_st == GS_HOLD) begin
                        add_event(EV_HOLD_REL, btn_code_type'(b));
                     end else begin
                        add_event(EV_RELEASE, btn_code_type'(b));
                     end
                  end
                  btn[b].long_mark = 1'b0;
               end
            end
         end
      end
   endfunction

   function automatic void predict_gesture_events(logic [REQ_TDATA_W-1:0] word);
      tick_ms    = word[31:0];
      tick_level = word[33:32];
      if (word[34]) btn[0].edge_due = 1'b1;
      if (word[35]) btn[1].edge_due = 1'b1;
      tick_events.delete();
      advance_button(0);
      advance_button(1);
      settle_events();
      if (tick_events.size() > 0) tick_events[tick_events.size()-1].last = 1'b1;
      foreach (tick_events[i]) events_due.push_back(tick_events[i]);
   endfunction

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         predict_gesture_events(req_tdata);
         ticks_taken++;
      end
   end

   always @(posedge clock) begin : check_events
      qent_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         words_checked++;
         if (events_due.size() == 0) begin
            $error("event word with none expected: kind %0d button %0d", rsp_tuser,
                   rsp_tdata[1:0]);
            fail_count++;
         end else begin
            want = events_due.pop_front();
            if (rsp_tuser !== want.kind) begin
               $error("event_kind: expected %0d, got %0d", want.kind, rsp_tuser);
               fail_count++;
            end
            if (rsp_tdata[1:0] !== want.button) begin
               $error("event_button: expected %0d, got %0d", want.button, rsp_tdata[1:0]);
               fail_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last_event: expected %0d, got %0d", want.last, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   // receiver: random stalls, plus a long hold-off whenever a test asks for one
   initial begin : rsp_side
      int quiet_left;
      int holdoffs_done;
      quiet_left    = 0;
      holdoffs_done = 0;
      forever begin
         @(posedge clock);
         if (holdoffs_done < holdoffs_asked) begin
            holdoffs_done++;
            quiet_left = HOLDOFF_CYCLES;
         end
         if (quiet_left > 0) begin
            quiet_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic set_idling(int phase);
      case (phase)
         0: begin
            send_idle_pct = 0;
            rsp_stall_pct = 0;
         end
         1: begin
            send_idle_pct = 62;
            rsp_stall_pct = 0;
         end
         2: begin
            send_idle_pct = 0;
            rsp_stall_pct = 62;
         end
         default: begin
            send_idle_pct = 32;
            rsp_stall_pct = 32;
         end
      endcase
   endtask

   // valid stays high across back-to-back words; it drops only for a gap
   task automatic send_tick(input bit [31:0] ms, input bit [1:0] lvl, input bit [1:0] edg);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tdata  <= {4'b0000, edg, lvl, ms};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   // let the last tick reach the queue before waiting for the queue to drain
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      repeat (4) @(posedge clock);
      while (events_due.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] idx, input bit [CFG_W-1:0] v);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= v;
      @(posedge clock);
      if (idx != CSR_UNUSED) timing[idx] = v;
   endtask

   task automatic program_timing(input cfg_type c);
      write_csr(CSR_DEBOUNCE, c.debounce);
      write_csr(CSR_DCLICK_GUARD, c.dclick_guard);
      write_csr(CSR_MAX_CLICK, c.max_click);
      write_csr(CSR_HOLD, c.hold);
      write_csr(CSR_HOLD_NOTIFY, c.hold_notify);
      write_csr(CSR_SINGLE_DELAY, c.single_delay);
      write_csr(CSR_LOCKOUT, c.lockout);
      write_csr(CSR_UNUSED, CFG_W'($urandom_range(16'hFFFF)));
      csr_we <= 1'b0;
   endtask

   // button sessions: presses, releases, bounces and long holds with random timing
   task automatic play_gestures(int count);
      int unsigned pick;
      int unsigned step;
      bit [1:0]    flip;
      bit [1:0]    extra;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pins == 2'b11 && pick < 50) step = $urandom_range(700, 4000);
         else if (pick < 55) step = $urandom_range(0, 40);
         else if (pick < 85) step = $urandom_range(41, 700);
         else step = $urandom_range(701, 4000);
         wall_ms += step * ms_scale;
         flip = 2'b00;
         if (pins == 2'b00 && $urandom_range(99) < 20) begin
            flip = 2'b11;
         end else if (pins == 2'b11 && $urandom_range(99) < 8) begin
            flip = 2'b11;
         end else begin
            for (int b = 0; b < 2; b++) begin
               if ($urandom_range(99) < (pins == 2'b11 ? 12 : 30)) flip[b] = 1'b1;
            end
         end
         // stray edge flags with no level change
         extra = ($urandom_range(99) < 6) ? 2'($urandom_range(3)) : 2'b00;
         pins ^= flip;
         send_tick(wall_ms, pins, flip | extra);
      end
   endtask

   task automatic test_directed_gestures();
      set_idling(3);
      // press stamped at zero counts as never stamped
      send_tick(32'd0,    2'b10, 2'b10);
      send_tick(32'd200,  2'b00, 2'b10);
      // press inside the double-click guard stays pending until the guard ends
      send_tick(32'd220,  2'b10, 2'b10);
      send_tick(32'd400,  2'b10, 2'b00);
      send_tick(32'd420,  2'b00, 2'b10);
      send_tick(32'd1000, 2'b01, 2'b01);
      send_tick(32'd1020, 2'b00, 2'b01);
      // bounce: press and release inside the windows
      send_tick(32'd1030, 2'b01, 2'b01);
      send_tick(32'd1040, 2'b00, 2'b01);
      // single hold, then hold released
      send_tick(32'd2000, 2'b01, 2'b01);
      send_tick(32'd3700, 2'b01, 2'b00);
      send_tick(32'd3800, 2'b00, 2'b01);
      // both-hold, long mark, repeated notification, both released
      send_tick(32'd5000, 2'b11, 2'b11);
      send_tick(32'd6100, 2'b11, 2'b00);
      send_tick(32'd8500, 2'b11, 2'b00);
      send_tick(32'd8510, 2'b11, 2'b00);
      send_tick(32'd8600, 2'b00, 2'b11);
      // inside the lockout after the both-release
      send_tick(32'd8700, 2'b01, 2'b01);
      send_tick(32'd8900, 2'b00, 2'b01);
      // press too long for a click: plain release
      send_tick(32'd9000, 2'b10, 2'b10);
      send_tick(32'd9800, 2'b00, 2'b10);
      // across the wrap of the ms counter
      send_tick(32'hFFFF_FFFF, 2'b01, 2'b01);
      send_tick(32'h0000_0100, 2'b00, 2'b01);
      // two clicks in one tick
      send_tick(32'h0000_0300, 2'b11, 2'b11);
      send_tick(32'h0000_0400, 2'b00, 2'b11);
   endtask

   task automatic test_queue_backpressure();
      wait_idle();
      set_idling(0);
      wall_ms = 32'd20000;
      holdoffs_asked++;
      repeat (20) begin
         wall_ms += 300;
         send_tick(wall_ms, 2'b11, 2'b11);
         wall_ms += 100;
         send_tick(wall_ms, 2'b00, 2'b11);
      end
   endtask

   task automatic test_timing_sweep();
      cfg_type setting;
      for (int s = 0; s < 5; s++) begin
         wait_idle();
         ms_scale = 1;
         wall_ms  = 32'd100000 * (s + 1);
         case (s)
            0: setting = CFG_RESET;
            1: setting = '0;
            2: begin
               setting  = '1;
               ms_scale = 40;
               wall_ms  = 32'hFFF0_0000;
            end
            3: setting = '{debounce: 16'd5, dclick_guard: 16'd10, max_click: 16'd60,
                           hold: 16'd150, hold_notify: 16'd400, single_delay: 16'd250,
                           lockout: 16'd80};
            default: begin
               setting.debounce     = CFG_W'($urandom_range(0, 300));
               setting.dclick_guard = CFG_W'($urandom_range(0, 300));
               setting.max_click    = CFG_W'($urandom_range(0, 1500));
               setting.hold         = CFG_W'($urandom_range(0, 3000));
               setting.hold_notify  = CFG_W'($urandom_range(0, 6000));
               setting.single_delay = CFG_W'($urandom_range(0, 4000));
               setting.lockout      = CFG_W'($urandom_range(0, 2000));
            end
         endcase
         program_timing(setting);
         set_idling(s % 4);
         pins = 2'b00;
         play_gestures(100);
      end
   endtask

   task automatic test_random_noise();
      wait_idle();
      set_idling(3);
      repeat (40) send_tick($urandom, 2'($urandom_range(3)), 2'($urandom_range(3)));
   endtask

   initial begin
      reset_model();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed_gestures();
      test_queue_backpressure();
      test_timing_sweep();
      test_random_noise();
      wait_idle();
      repeat (8) @(posedge clock);
      $display("Run covered %0d ticks and %0d event words: directed gestures, a long",
               ticks_taken, words_checked);
      $display("output hold-off, five timing settings incl. extremes, and random noise.");
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
